>>> src/cbc_pkg.sv
// cbc_pkg: shared types and constants of the cartridge bank controller
// no dependencies; used by the channel interfaces and the top level

package cbc_pkg;

  // bank limits built into the cartridge slot
  localparam int unsigned MAX_ROM_BANKS = 512;
  localparam int unsigned MAX_RAM_BANKS = 16;

  localparam int unsigned ADDR_W      = 16;
  localparam int unsigned DATA_W      = 8;
  localparam int unsigned OFFSET_W    = 23;
  localparam int unsigned ROM_BANK_W  = 9;
  localparam int unsigned RAM_BANK_W  = 4;
  localparam int unsigned ROM_COUNT_W = 10;
  localparam int unsigned RAM_COUNT_W = 5;
  localparam int unsigned KIND_W      = 3;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 10;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KIND      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROM_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RAM_COUNT = 2'd2;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE   = 3'd0,
    KIND_MBC1   = 3'd1,
    KIND_MBC2   = 3'd2,
    KIND_MBC3   = 3'd3,
    KIND_MBC5   = 3'd4,
    KIND_RUMBLE = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    REGION_NONE = 2'd0,
    REGION_ROM  = 2'd1,
    REGION_RAM  = 2'd2,
    REGION_CTRL = 2'd3
  } region_t;

  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // 4 KiB pages of the control range
  localparam logic [3:0] PAGE_ROM_LO = 4'h2;
  localparam logic [3:0] PAGE_ROM_HI = 4'h3;
  localparam logic [3:0] PAGE_MID_0  = 4'h4;
  localparam logic [3:0] PAGE_MID_1  = 4'h5;
  localparam logic [3:0] PAGE_MODE_0 = 4'h6;
  localparam logic [3:0] PAGE_MODE_1 = 4'h7;

  localparam logic [ROM_BANK_W-1:0] ROM_BANK_RESET = 9'd1;

endpackage

>>> src/cbc_req_if.sv
// cbc_req_if: valid/ready channel carrying one cartridge bus access
// depends on cbc_pkg

interface cbc_req_if;
  import cbc_pkg::*;

  logic              valid;
  logic              ready;
  logic              req_type;
  logic [ADDR_W-1:0] bus_address;
  logic [DATA_W-1:0] bus_data;

  modport source (output valid, req_type, bus_address, bus_data, input ready);
  modport sink   (input valid, req_type, bus_address, bus_data, output ready);
endinterface

>>> src/cbc_rsp_if.sv
// cbc_rsp_if: valid/ready channel carrying one mapping result
// depends on cbc_pkg

interface cbc_rsp_if;
  import cbc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [1:0]            target_region;
  logic [OFFSET_W-1:0]   physical_offset;
  logic [ROM_BANK_W-1:0] rom_bank_value;
  logic [RAM_BANK_W-1:0] ram_bank_value;
  logic [1:0]            switch_refused;

  modport source (output valid, target_region, physical_offset, rom_bank_value,
                  ram_bank_value, switch_refused, input ready);
  modport sink   (input valid, target_region, physical_offset, rom_bank_value,
                  ram_bank_value, switch_refused, output ready);
endinterface

>>> src/cartridge_bank_controller_unit.sv
// cartridge_bank_controller_unit: MBC1/MBC2/MBC3/MBC5 style bank register
// decode and ROM/RAM address translation; depends on cbc_pkg, cbc_req_if, cbc_rsp_if
//
//   channel  | direction | contents
//   in_bus   | sink      | req_type, bus_address, bus_data
//   out_res  | source    | target_region, physical_offset, bank values, refusal flags
//   cfg_*    | write     | controller kind, ROM bank count, RAM bank count
//
// one transaction per cycle while out_res is not stalled; the result is registered and shows in the cycle
// after acceptance, the bank registers update at the same edge
// rst_n (synchronous) restores bank 1 / RAM bank 0 / mode 0 and the config defaults
// a stalled result holds; a new transaction is taken while the result register
// is empty or out_res.ready is high

module cartridge_bank_controller_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  cbc_req_if.sink                      in_bus,
  cbc_rsp_if.source                    out_res,
  input  logic                         cfg_we,
  input  logic [cbc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cbc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import cbc_pkg::*;

  localparam logic [ROM_COUNT_W-1:0] ROM_MAX = ROM_COUNT_W'(MAX_ROM_BANKS);
  localparam logic [RAM_COUNT_W-1:0] RAM_MAX = RAM_COUNT_W'(MAX_RAM_BANKS);

  // configuration
  logic [KIND_W-1:0]      kind_r;
  logic [ROM_COUNT_W-1:0] rom_count_r;
  logic [RAM_COUNT_W-1:0] ram_count_r;

  // bank state
  logic [ROM_BANK_W-1:0]  rom_bank_r, rom_bank_nxt;
  logic [RAM_BANK_W-1:0]  ram_bank_r, ram_bank_nxt;
  logic                   mode_r, mode_nxt;
  logic [ROM_BANK_W-1:0]  map_rom_r, map_rom_nxt;
  logic [RAM_BANK_W-1:0]  map_ram_r, map_ram_nxt;

  // result register
  logic                   out_valid_r;
  logic [1:0]             region_r, region_nxt;
  logic [OFFSET_W-1:0]    offset_r, offset_nxt;
  logic [ROM_BANK_W-1:0]  rom_val_r;
  logic [RAM_BANK_W-1:0]  ram_val_r;
  logic [1:0]             refused_r, refused_nxt;

  logic                   accept;
  logic [3:0]             page;
  logic                   page_lo, page_mid, page_mode;
  logic [DATA_W-1:0]      wdata;
  logic [ROM_COUNT_W-1:0] rom_lim;
  logic [RAM_COUNT_W-1:0] ram_lim;
  logic                   is_cart_rom, is_cart_ram;

  function automatic logic [6:0] nz_or_one(input logic [6:0] v);
    return (v == 7'd0) ? 7'd1 : v;
  endfunction

  assign accept       = in_bus.valid && in_bus.ready;
  assign in_bus.ready = !out_valid_r || out_res.ready;

  assign page      = in_bus.bus_address[15:12];
  assign page_lo   = (page == PAGE_ROM_LO) || (page == PAGE_ROM_HI);
  assign page_mid  = (page == PAGE_MID_0) || (page == PAGE_MID_1);
  assign page_mode = (page == PAGE_MODE_0) || (page == PAGE_MODE_1);

  assign is_cart_rom = !in_bus.bus_address[15];
  assign is_cart_ram = (in_bus.bus_address[15:13] == 3'b101);

  assign rom_lim = (rom_count_r < ROM_MAX) ? rom_count_r : ROM_MAX;
  assign ram_lim = (ram_count_r < RAM_MAX) ? ram_count_r : RAM_MAX;

  // rumble carts drop the motor bit from RAM bank writes
  assign wdata = (kind_r == KIND_RUMBLE && page_mid) ? (in_bus.bus_data & 8'h07)
                                                      : in_bus.bus_data;

  always_comb begin
    rom_bank_nxt = rom_bank_r;
    ram_bank_nxt = ram_bank_r;
    mode_nxt     = mode_r;
    map_rom_nxt  = map_rom_r;
    map_ram_nxt  = map_ram_r;
    region_nxt   = REGION_NONE;
    offset_nxt   = '0;
    refused_nxt  = 2'b00;

    if (is_cart_rom && in_bus.req_type == REQ_WRITE) begin
      unique case (kind_r)
        KIND_MBC1: begin
          if (page_lo) begin
            rom_bank_nxt = {2'b00, rom_bank_r[6:5],
                            ((wdata[4:0] == 5'd0) ? 5'd1 : wdata[4:0])};
          end else if (page_mid) begin
            if (mode_r) begin
              ram_bank_nxt = {2'b00, wdata[1:0]};
            end else begin
              rom_bank_nxt = {2'b00, wdata[1:0], rom_bank_r[4:0]};
            end
          end else if (page_mode) begin
            mode_nxt = wdata[0];
          end
        end
        KIND_MBC2: begin
          if (in_bus.bus_address[8]) begin
            rom_bank_nxt = {5'd0, ((wdata[3:0] == 4'd0) ? 4'd1 : wdata[3:0])};
          end
        end
        KIND_MBC3: begin
          if (page_lo) begin
            rom_bank_nxt = {2'b00, nz_or_one(wdata[6:0])};
          end else if (page_mid) begin
            ram_bank_nxt = {2'b00, wdata[1:0]};
          end
        end
        KIND_MBC5, KIND_RUMBLE: begin
          if (page == PAGE_ROM_LO) begin
            rom_bank_nxt = {rom_bank_r[8], wdata};
          end else if (page == PAGE_ROM_HI) begin
            rom_bank_nxt = {wdata[0], rom_bank_r[7:0]};
          end else if (page_mid) begin
            ram_bank_nxt = wdata[3:0];
          end
        end
        default: begin
        end
      endcase

      region_nxt = REGION_CTRL;
      // retry the mapping; an out of range bank keeps the old one
      if ({1'b0, rom_bank_nxt} >= rom_lim) begin
        refused_nxt[0] = 1'b1;
      end else begin
        map_rom_nxt = rom_bank_nxt;
      end
      if (ram_bank_nxt != '0 && {1'b0, ram_bank_nxt} >= ram_lim) begin
        refused_nxt[1] = 1'b1;
      end else begin
        map_ram_nxt = ram_bank_nxt;
      end
    end else if (is_cart_rom) begin
      region_nxt = REGION_ROM;
      if (!in_bus.bus_address[14]) begin
        offset_nxt = OFFSET_W'(in_bus.bus_address);
      end else begin
        offset_nxt = {map_rom_r, in_bus.bus_address[13:0]};
      end
    end else if (is_cart_ram) begin
      region_nxt = REGION_RAM;
      offset_nxt = OFFSET_W'({map_ram_r, in_bus.bus_address[12:0]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r      <= KIND_NONE;
      rom_count_r <= ROM_COUNT_W'(2);
      ram_count_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KIND:      kind_r      <= cfg_wdata[KIND_W-1:0];
        CFG_ROM_COUNT: rom_count_r <= cfg_wdata[ROM_COUNT_W-1:0];
        CFG_RAM_COUNT: ram_count_r <= cfg_wdata[RAM_COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_bank_r  <= ROM_BANK_RESET;
      ram_bank_r  <= '0;
      mode_r      <= 1'b0;
      map_rom_r   <= ROM_BANK_RESET;
      map_ram_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        rom_bank_r  <= rom_bank_nxt;
        ram_bank_r  <= ram_bank_nxt;
        mode_r      <= mode_nxt;
        map_rom_r   <= map_rom_nxt;
        map_ram_r   <= map_ram_nxt;
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      region_r  <= region_nxt;
      offset_r  <= offset_nxt;
      rom_val_r <= rom_bank_nxt;
      ram_val_r <= ram_bank_nxt;
      refused_r <= refused_nxt;
    end
  end

  assign out_res.valid           = out_valid_r;
  assign out_res.target_region   = region_r;
  assign out_res.physical_offset = offset_r;
  assign out_res.rom_bank_value  = rom_val_r;
  assign out_res.ram_bank_value  = ram_val_r;
  assign out_res.switch_refused  = refused_r;

endmodule

>>> tb/sv/cartridge_bank_controller_unit_tb.sv
// cartridge_bank_controller_unit_tb: self-checking bench for the cartridge bank controller
// depends on cbc_pkg, cbc_req_if, cbc_rsp_if and cartridge_bank_controller_unit
// mirrors the bank registers, predicts each mapping result and checks it field by field

module cartridge_bank_controller_unit_tb;
  import cbc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_LIMIT = 5000;
  localparam int unsigned HOLD_CYCLES = 300;

  // controller kinds outside the defined set
  localparam logic [KIND_W-1:0] KIND_UNDEF_6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_UNDEF_7 = 3'd7;

  typedef struct packed {
    region_t               region;
    logic [OFFSET_W-1:0]   offset;
    logic [ROM_BANK_W-1:0] rom_bank;
    logic [RAM_BANK_W-1:0] ram_bank;
    logic [1:0]            refused;
  } mapping_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  cbc_req_if bus_if ();
  cbc_rsp_if res_if ();

  cartridge_bank_controller_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (bus_if),
    .out_res   (res_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // mirror of the cartridge registers
  logic [KIND_W-1:0]      kind_m;
  logic [ROM_COUNT_W-1:0] rom_count_m;
  logic [RAM_COUNT_W-1:0] ram_count_m;
  logic [ROM_BANK_W-1:0]  rom_bank_m;
  logic [ROM_BANK_W-1:0]  rom_mapped_m;
  logic [RAM_BANK_W-1:0]  ram_bank_m;
  logic [RAM_BANK_W-1:0]  ram_mapped_m;
  logic                   mode_m;

  mapping_t    mapping_queue[$];
  int unsigned cycle_count;
  int unsigned accesses_sent;
  int unsigned results_checked;
  int unsigned config_phases;
  int unsigned mismatches;
  bit          idle_en;
  int unsigned sink_hold;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", CYCLE_LIMIT,
             mapping_queue.size());
    $display("RESULT: ERROR");
    $finish;
  end

  // result receiver: random stall bursts plus a long hold on request
  initial begin
    int unsigned stall;
    stall = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold > 0) begin
        sink_hold--;
        res_if.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        res_if.ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(0, 16);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    mapping_t want;
    if (rst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      if (mapping_queue.size() == 0) begin
        $error("result with nothing expected: region %0d offset 0x%0h",
               res_if.target_region, res_if.physical_offset);
        mismatches++;
      end else begin
        want = mapping_queue.pop_front();
        results_checked++;
        check_field("target_region", want.region, res_if.target_region);
        check_field("physical_offset", want.offset, res_if.physical_offset);
        check_field("rom_bank_value", want.rom_bank, res_if.rom_bank_value);
        check_field("ram_bank_value", want.ram_bank, res_if.ram_bank_value);
        check_field("switch_refused", want.refused, res_if.switch_refused);
      end
    end
  end

  // updates the mirrored bank registers and queues the expected mapping
  task automatic predict_mapping(input logic rw, input logic [ADDR_W-1:0] a,
                                 input logic [DATA_W-1:0] d);
    mapping_t    m;
    logic [3:0]  page;
    logic        lo_page;
    logic        mid_page;
    logic [7:0]  wd;
    int unsigned rom_lim;
    int unsigned ram_lim;
    m = '0;
    m.region = REGION_NONE;
    page = a[15:12];
    lo_page = (page == PAGE_ROM_LO) || (page == PAGE_ROM_HI);
    mid_page = (page == PAGE_MID_0) || (page == PAGE_MID_1);
    if (a < 16'h8000) begin
      if (rw == REQ_WRITE) begin
        rom_lim = (rom_count_m < MAX_ROM_BANKS) ? rom_count_m : MAX_ROM_BANKS;
        ram_lim = (ram_count_m < MAX_RAM_BANKS) ? ram_count_m : MAX_RAM_BANKS;
        wd = d;
        case (kind_m)
          KIND_MBC1: begin
            if (lo_page) begin
              rom_bank_m = {2'b00, rom_bank_m[6:5], ((d[4:0] == 5'd0) ? 5'd1 : d[4:0])};
            end else if (mid_page) begin
              if (mode_m) ram_bank_m = {2'b00, d[1:0]};
              else rom_bank_m = {2'b00, d[1:0], rom_bank_m[4:0]};
            end else if (page == PAGE_MODE_0 || page == PAGE_MODE_1) begin
              mode_m = d[0];
            end
          end
          KIND_MBC2: begin
            if (a[8]) rom_bank_m = (d[3:0] == 4'd0) ? 9'd1 : {5'd0, d[3:0]};
          end
          KIND_MBC3: begin
            if (lo_page) rom_bank_m = (d[6:0] == 7'd0) ? 9'd1 : {2'b00, d[6:0]};
            else if (mid_page) ram_bank_m = {2'b00, d[1:0]};
          end
          KIND_MBC5, KIND_RUMBLE: begin
            // motor bit never reaches the RAM bank
            if (kind_m == KIND_RUMBLE && mid_page) wd = {5'd0, d[2:0]};
            if (page == PAGE_ROM_LO) rom_bank_m = {rom_bank_m[8], wd};
            else if (page == PAGE_ROM_HI) rom_bank_m = {wd[0], rom_bank_m[7:0]};
            else if (mid_page) ram_bank_m = wd[3:0];
          end
          default: ;
        endcase
        m.region = REGION_CTRL;
        if (rom_bank_m >= rom_lim) m.refused[0] = 1'b1;
        else rom_mapped_m = rom_bank_m;
        if (ram_bank_m != 4'd0 && ram_bank_m >= ram_lim) m.refused[1] = 1'b1;
        else ram_mapped_m = ram_bank_m;
      end else begin
        m.region = REGION_ROM;
        m.offset = (a < 16'h4000) ? {7'd0, a} : {rom_mapped_m, a[13:0]};
      end
    end else if (a >= 16'hA000 && a < 16'hC000) begin
      m.region = REGION_RAM;
      m.offset = {6'd0, ram_mapped_m, a[12:0]};
    end
    m.rom_bank = rom_bank_m;
    m.ram_bank = ram_bank_m;
    mapping_queue.push_back(m);
  endtask

  task automatic send_access(input logic rw, input logic [ADDR_W-1:0] a,
                             input logic [DATA_W-1:0] d);
    int unsigned gap;
    if (idle_en && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 17);
      bus_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    bus_if.valid       <= 1'b1;
    bus_if.req_type    <= rw;
    bus_if.bus_address <= a;
    bus_if.bus_data    <= d;
    @(posedge clk);
    while (bus_if.ready !== 1'b1) @(posedge clk);
    predict_mapping(rw, a, d);
    accesses_sent++;
  endtask

  task automatic wait_for_results();
    bus_if.valid <= 1'b0;
    while (mapping_queue.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic apply_config(input logic [KIND_W-1:0] kind, input int unsigned rom_banks,
                              input int unsigned ram_banks);
    wait_for_results();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_KIND;
    cfg_wdata <= {7'd0, kind};
    @(posedge clk);
    cfg_index <= CFG_ROM_COUNT;
    cfg_wdata <= rom_banks[ROM_COUNT_W-1:0];
    @(posedge clk);
    cfg_index <= CFG_RAM_COUNT;
    cfg_wdata <= {5'd0, ram_banks[RAM_COUNT_W-1:0]};
    @(posedge clk);
    cfg_we <= 1'b0;
    kind_m      = kind;
    rom_count_m = rom_banks[ROM_COUNT_W-1:0];
    ram_count_m = ram_banks[RAM_COUNT_W-1:0];
    config_phases++;
  endtask

  // mostly bank control writes and reads through the switched windows
  task automatic random_access();
    int unsigned       pick;
    logic              rw;
    logic [ADDR_W-1:0] a;
    logic [DATA_W-1:0] d;
    pick = $urandom_range(0, 99);
    rw = 1'($urandom_range(0, 1));
    d = DATA_W'($urandom_range(0, 255));
    if (pick < 50) begin
      rw = REQ_WRITE;
      a = ADDR_W'($urandom_range(0, 16'h7FFF));
      // small bank numbers make switches inside the configured counts more likely
      if ($urandom_range(0, 1) == 1) d = DATA_W'($urandom_range(0, 31));
    end else if (pick < 80) begin
      rw = REQ_READ;
      a = ADDR_W'($urandom_range(0, 16'h7FFF));
    end else if (pick < 93) begin
      a = ADDR_W'($urandom_range(16'hA000, 16'hBFFF));
    end else if (pick < 97) begin
      a = ADDR_W'($urandom_range(16'h8000, 16'h9FFF));
    end else begin
      a = ADDR_W'($urandom_range(16'hC000, 16'hFFFF));
    end
    send_access(rw, a, d);
  endtask

  task automatic test_reset_defaults();
    send_access(REQ_READ, 16'h0000, 8'h00);
    send_access(REQ_READ, 16'h4000, 8'hFF);
    send_access(REQ_READ, 16'h7FFF, 8'h00);
    send_access(REQ_WRITE, 16'hA000, 8'hFF);
    send_access(REQ_WRITE, 16'h2000, 8'h05);
    send_access(REQ_WRITE, 16'h9FFF, 8'h01);
    send_access(REQ_READ, 16'hFFFF, 8'h00);
  endtask

  task automatic test_mbc1_banking();
    apply_config(KIND_MBC1, 128, 4);
    send_access(REQ_WRITE, 16'h0000, 8'h0A);
    send_access(REQ_WRITE, 16'h2000, 8'h00);
    send_access(REQ_WRITE, 16'h3FFF, 8'hFF);
    send_access(REQ_WRITE, 16'h4000, 8'h03);
    send_access(REQ_READ, 16'h7FFF, 8'h00);
    send_access(REQ_WRITE, 16'h6000, 8'h01);
    send_access(REQ_WRITE, 16'h5FFF, 8'h03);
    send_access(REQ_READ, 16'hBFFF, 8'h00);
  endtask

  task automatic test_other_controllers();
    apply_config(KIND_MBC2, 16, 1);
    send_access(REQ_WRITE, 16'h0100, 8'h00);
    send_access(REQ_WRITE, 16'h21FF, 8'hFF);
    send_access(REQ_WRITE, 16'h2000, 8'h07);
    apply_config(KIND_MBC3, 64, 0);
    send_access(REQ_WRITE, 16'h2000, 8'h7F);
    send_access(REQ_WRITE, 16'h4000, 8'hFF);
    apply_config(KIND_MBC5, MAX_ROM_BANKS, MAX_RAM_BANKS);
    send_access(REQ_WRITE, 16'h2000, 8'hFF);
    send_access(REQ_WRITE, 16'h3000, 8'h01);
    send_access(REQ_READ, 16'h7FFF, 8'h00);
    send_access(REQ_WRITE, 16'h4000, 8'h0F);
    apply_config(KIND_RUMBLE, 1023, 31);
    send_access(REQ_WRITE, 16'h5000, 8'h0F);
    send_access(REQ_WRITE, 16'h2000, 8'h00);
    // zero ROM count refuses every bank, undefined kinds touch nothing
    apply_config(KIND_UNDEF_6, 0, 16);
    send_access(REQ_WRITE, 16'h2000, 8'h03);
    apply_config(KIND_UNDEF_7, 1, 2);
    send_access(REQ_WRITE, 16'h4000, 8'h01);
  endtask

  task automatic test_random_mapping();
    int unsigned rom_banks;
    int unsigned ram_banks;
    for (int phase = 0; phase < 12; phase++) begin
      case ($urandom_range(0, 7))
        0: rom_banks = 1;
        1: rom_banks = MAX_ROM_BANKS;
        2: rom_banks = 1023;
        default: rom_banks = 1 << $urandom_range(1, 9);
      endcase
      case ($urandom_range(0, 5))
        0: ram_banks = 0;
        1: ram_banks = MAX_RAM_BANKS;
        2: ram_banks = 31;
        default: ram_banks = 1 << $urandom_range(0, 4);
      endcase
      apply_config(kind_t'(phase % 6), rom_banks, ram_banks);
      repeat (95) random_access();
    end
  endtask

  task automatic test_backpressure();
    // receiver holds off while transactions keep coming
    sink_hold = HOLD_CYCLES;
    repeat (40) random_access();
    wait_for_results();
    repeat (40) random_access();
  endtask

  task automatic test_streaming();
    idle_en = 1'b0;
    repeat (200) random_access();
  endtask

  initial begin
    int unsigned drain;
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= CFG_KIND;
    cfg_wdata          <= '0;
    bus_if.valid       <= 1'b0;
    bus_if.req_type    <= REQ_READ;
    bus_if.bus_address <= '0;
    bus_if.bus_data    <= '0;
    idle_en      = 1'b1;
    sink_hold    = 0;
    kind_m       = KIND_NONE;
    rom_count_m  = 10'd2;
    ram_count_m  = 5'd0;
    rom_bank_m   = ROM_BANK_RESET;
    rom_mapped_m = ROM_BANK_RESET;
    ram_bank_m   = 4'd0;
    ram_mapped_m = 4'd0;
    mode_m       = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_mbc1_banking();
    test_other_controllers();
    test_random_mapping();
    test_backpressure();
    test_streaming();

    bus_if.valid <= 1'b0;
    drain = 0;
    while (mapping_queue.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (8) @(posedge clk);
    if (mapping_queue.size() != 0) begin
      $error("%0d expected results never arrived", mapping_queue.size());
      mismatches += mapping_queue.size();
    end
    $display("%0d bus accesses over %0d bank configurations, %0d results checked",
             accesses_sent, config_phases, results_checked);
    $display("all controller kinds, refused switches, long result stall and streaming; %0d errors",
             mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
